[src/writeback_cache_controller_assert.svh]
// assertion macros for the cache controller
`ifndef WRITEBACK_CACHE_CONTROLLER_ASSERT_SVH
`define WRITEBACK_CACHE_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WBC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WBC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WBC_ASSERT(label, prop, msg)
`define WBC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[src/wbc_pkg.sv]
package wbc_pkg;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] address;
		logic [31:0] write_data;
		logic [1:0]  access_size;
		logic [15:0] cycles;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] mem_address;
		logic [31:0] mem_data;
		logic [31:0] read_data;
		logic        hit;
		logic [15:0] latency;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic        last;
	} rsp_t;

	localparam logic [2:0] CMD_READ  = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_FILL  = 3'd2;
	localparam logic [2:0] CMD_TICK  = 3'd3;
	localparam logic [2:0] CMD_FLUSH = 3'd4;

	localparam logic [1:0] KIND_DONE     = 2'd0;
	localparam logic [1:0] KIND_WB       = 2'd1;
	localparam logic [1:0] KIND_FILL_REQ = 2'd2;
	localparam logic [1:0] KIND_STATUS   = 2'd3;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;

	localparam logic [0:0] REG_TWO_WAY      = 1'b0;
	localparam logic [0:0] REG_MISS_LATENCY = 1'b1;

	localparam logic [31:0] MASK_BYTE     = 32'h0000_00FF;
	localparam logic [31:0] MASK_HALF     = 32'h0000_FFFF;
	localparam logic [31:0] KEEP_BYTE     = 32'hFFFF_FF00;
	localparam logic [31:0] KEEP_HALF     = 32'hFFFF_0000;

	function automatic logic [31:0] size_mask(input logic [31:0] v, input logic [1:0] size);
		logic [31:0] r;
		case (size)
			SIZE_BYTE: r = v & MASK_BYTE;
			SIZE_HALF: r = v & MASK_HALF;
			default:   r = v;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] merge_word(input logic [31:0] cur, input logic [31:0] v,
			input logic [1:0] size);
		logic [31:0] r;
		case (size)
			SIZE_BYTE: r = (cur & KEEP_BYTE) | (v & MASK_BYTE);
			SIZE_HALF: r = (cur & KEEP_HALF) | (v & MASK_HALF);
			default:   r = v;
		endcase
		return r;
	endfunction

endpackage

[src/writeback_cache_controller.sv]
// write-back, write-allocate cache controller, direct-mapped or two-way with lru
// request channel req/req_valid/req_stall: read, write, fill word, stall tick, flush set
// response channel rsp/rsp_valid/rsp_stall: one registered result slot
// config port: cfg_write with cfg_index 0 two_way, 1 miss_latency, taken at once
// one request at a time; a hit passes the lookup state and answers from the check state,
// and a stall tick answers from its own state
// a miss writes back a dirty victim line word by word, then sends the fill request;
// each fill word passes the fill write state; the final one then reads and answers
// a flush writes back each dirty line of its set, or else answers with a status
// the tag and data memories have registered reads, and writeback sends one word
// per data memory read
// after reset a clearing pass invalidates all NUM_LINES lines and sets
// the lru bits; req_stall is high during it
// while rsp_stall holds a result, the controller waits before producing the next
// result; req_stall stays high until the request in progress has finished
module writeback_cache_controller #(
	parameter int NUM_LINES      = 64,
	parameter int WORDS_PER_LINE = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [0:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          req_valid,
	output logic          req_stall,
	input  wbc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output wbc_pkg::rsp_t rsp
);

	`include "writeback_cache_controller_assert.svh"

	localparam int OB      = 2 + $clog2(WORDS_PER_LINE + 1) - 1;
	localparam int IB_D    = $clog2(NUM_LINES + 1) - 1;
	localparam int LRU_D   = NUM_LINES / 2;
	localparam int IB_T    = $clog2(LRU_D + 1) - 1;
	localparam int MAW     = $clog2(NUM_LINES);
	localparam int LAW     = (LRU_D > 1) ? $clog2(LRU_D) : 1;
	localparam int TAGW    = 32 - OB - IB_T;
	localparam int MW      = TAGW + 2;
	localparam int DDEPTH  = NUM_LINES * WORDS_PER_LINE;
	localparam int DAW     = $clog2(DDEPTH);
	localparam int WW      = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
	localparam int CW      = $clog2(WORDS_PER_LINE + 1);
	localparam logic [31:0] SMASK_D = (32'd1 << IB_D) - 32'd1;
	localparam logic [31:0] SMASK_T = (32'd1 << IB_T) - 32'd1;
	localparam logic [31:0] OMASK   = (32'd1 << OB) - 32'd1;

	typedef enum logic [10:0] {
		S_CLEAR     = 11'b000_0000_0001,
		S_IDLE      = 11'b000_0000_0010,
		S_LOOK      = 11'b000_0000_0100,
		S_CHECK     = 11'b000_0000_1000,
		S_WB_RD     = 11'b000_0001_0000,
		S_WB_OUT    = 11'b000_0010_0000,
		S_REQ       = 11'b000_0100_0000,
		S_FILL_WR   = 11'b000_1000_0000,
		S_FILL_RD   = 11'b001_0000_0000,
		S_FILL_DONE = 11'b010_0000_0000,
		S_TICK      = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	logic [MAW-1:0]      clr_q;
	logic                two_way_q;
	logic [15:0]         miss_latency_q;
	wbc_pkg::req_t       item_q;
	logic                pend_valid_q;
	logic [31:0]         pend_addr_q;
	logic [31:0]         pend_data_q;
	logic [1:0]          pend_size_q;
	logic                pend_write_q;
	logic [MAW-1:0]      pend_line_q;
	logic [CW-1:0]       fill_cnt_q;
	logic [15:0]         stall_q;
	logic [31:0]         hits_q;
	logic [31:0]         misses_q;
	logic [MAW-1:0]      vic_line_q;
	logic [MAW-1:0]      wb_line_q;
	logic [TAGW-1:0]     wb_tag_q;
	logic [TAGW-1:0]     wb_tag1_q;
	logic [WW-1:0]       wb_word_q;
	logic                wb_second_q;
	logic                out_valid_q;
	wbc_pkg::rsp_t       out_q;

	logic                meta_we;
	logic [MAW-1:0]      meta_waddr;
	logic [MW-1:0]       meta_wdata;
	logic [MAW-1:0]      meta_raddr0;
	logic [MAW-1:0]      meta_raddr1;
	logic [MW-1:0]       meta_rdata0;
	logic [MW-1:0]       meta_rdata1;
	logic                lru_we;
	logic [LAW-1:0]      lru_waddr;
	logic                lru_wdata;
	logic [LAW-1:0]      lru_raddr;
	logic                lru_rdata;
	logic                data_we;
	logic [DAW-1:0]      data_waddr;
	logic [31:0]         data_wdata;
	logic [DAW-1:0]      data_raddr0;
	logic [DAW-1:0]      data_raddr1;
	logic [31:0]         data_rdata0;
	logic [31:0]         data_rdata1;

	logic [31:0]         set32;
	logic [31:0]         tag32;
	logic [31:0]         word32;
	logic [31:0]         ptag32;
	logic [31:0]         pword32;
	logic [MAW-1:0]      line0;
	logic [MAW-1:0]      line1;
	logic                v0, v1, d0, d1;
	logic [TAGW-1:0]     t0, t1;
	logic                hit0, hit1, hit_any;
	logic                is_wr, is_flush;
	logic                vic_way1;
	logic [MAW-1:0]      vic_line;
	logic                wb0, wb1;
	logic                out_free;
	logic                wb_last_word;
	logic [CW-1:0]       fill_next;
	logic [15:0]         tick_new;
	logic                emit;
	wbc_pkg::rsp_t       rsp_d;

	function automatic logic [31:0] set_of(input logic [31:0] a, input logic tw);
		return tw ? ((a >> OB) & SMASK_T) : ((a >> OB) & SMASK_D);
	endfunction

	function automatic logic [31:0] tag_of(input logic [31:0] a, input logic tw);
		return tw ? (a >> (OB + IB_T)) : (a >> (OB + IB_D));
	endfunction

	function automatic logic [31:0] base_of(input logic [31:0] t, input logic [31:0] s,
			input logic tw);
		return tw ? ((t << (OB + IB_T)) | (s << OB)) : ((t << (OB + IB_D)) | (s << OB));
	endfunction

	function automatic logic [DAW-1:0] daddr(input logic [MAW-1:0] ln, input logic [31:0] wd);
		return DAW'(32'(ln) * 32'(WORDS_PER_LINE) + wd);
	endfunction

	function automatic wbc_pkg::rsp_t make_rsp(input logic [1:0] kind, input logic [31:0] maddr,
			input logic [31:0] mdata, input logic [31:0] rdata, input logic hit,
			input logic [15:0] lat, input logic [31:0] hc, input logic [31:0] mc,
			input logic last);
		wbc_pkg::rsp_t r;
		r.kind        = kind;
		r.mem_address = maddr;
		r.mem_data    = mdata;
		r.read_data   = rdata;
		r.hit         = hit;
		r.latency     = lat;
		r.hit_count   = hc;
		r.miss_count  = mc;
		r.last        = last;
		return r;
	endfunction

	wbc_tag_store #(
		.LINES     (NUM_LINES),
		.MW        (MW),
		.AW        (MAW),
		.LRU_DEPTH (LRU_D),
		.LAW       (LAW)
	) u_tag_store (
		.clk         (clk),
		.meta_we     (meta_we),
		.meta_waddr  (meta_waddr),
		.meta_wdata  (meta_wdata),
		.meta_raddr0 (meta_raddr0),
		.meta_raddr1 (meta_raddr1),
		.meta_rdata0 (meta_rdata0),
		.meta_rdata1 (meta_rdata1),
		.lru_we      (lru_we),
		.lru_waddr   (lru_waddr),
		.lru_wdata   (lru_wdata),
		.lru_raddr   (lru_raddr),
		.lru_rdata   (lru_rdata)
	);

	wbc_data_store #(
		.DEPTH (DDEPTH),
		.AW    (DAW)
	) u_data_store (
		.clk    (clk),
		.we     (data_we),
		.waddr  (data_waddr),
		.wdata  (data_wdata),
		.raddr0 (data_raddr0),
		.raddr1 (data_raddr1),
		.rdata0 (data_rdata0),
		.rdata1 (data_rdata1)
	);

	assign set32   = set_of(item_q.address, two_way_q);
	assign tag32   = tag_of(item_q.address, two_way_q);
	assign word32  = (item_q.address & OMASK) >> 2;
	assign ptag32  = tag_of(pend_addr_q, two_way_q);
	assign pword32 = (pend_addr_q & OMASK) >> 2;
	assign line0   = MAW'(set32);
	assign line1   = MAW'(32'(LRU_D) + set32);

	assign v0 = meta_rdata0[MW-1];
	assign d0 = meta_rdata0[MW-2];
	assign t0 = meta_rdata0[TAGW-1:0];
	assign v1 = meta_rdata1[MW-1];
	assign d1 = meta_rdata1[MW-2];
	assign t1 = meta_rdata1[TAGW-1:0];

	assign hit0     = v0 && (32'(t0) == tag32);
	assign hit1     = two_way_q && v1 && (32'(t1) == tag32);
	assign hit_any  = hit0 || hit1;
	assign is_wr    = item_q.command == wbc_pkg::CMD_WRITE;
	assign is_flush = item_q.command == wbc_pkg::CMD_FLUSH;
	assign vic_way1 = two_way_q && !lru_rdata;
	assign vic_line = vic_way1 ? line1 : line0;
	assign wb0      = v0 && d0;
	assign wb1      = two_way_q && v1 && d1;
	assign out_free = !out_valid_q || !rsp_stall;
	assign wb_last_word = wb_word_q == WW'(WORDS_PER_LINE - 1);
	assign fill_next    = fill_cnt_q + CW'(1);
	assign tick_new     = (item_q.cycles > stall_q) ? 16'd0 : stall_q - item_q.cycles;

	always_comb begin
		meta_we     = 1'b0;
		meta_waddr  = line0;
		meta_wdata  = '0;
		meta_raddr0 = line0;
		meta_raddr1 = line1;
		lru_we      = 1'b0;
		lru_waddr   = LAW'(set32);
		lru_wdata   = 1'b1;
		lru_raddr   = LAW'(set32);
		data_we     = 1'b0;
		data_waddr  = daddr(line0, word32);
		data_wdata  = item_q.write_data;
		data_raddr0 = daddr(line0, word32);
		data_raddr1 = daddr(line1, word32);
		emit        = 1'b0;
		rsp_d       = make_rsp(wbc_pkg::KIND_DONE, '0, '0, '0, 1'b0, '0, hits_q, misses_q, 1'b1);
		case (state_q)
			S_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
				lru_we     = 32'(clr_q) < 32'(LRU_D);
				lru_waddr  = LAW'(clr_q);
			end
			S_CHECK: begin
				if (!is_flush) begin
					if (hit_any) begin
						if (out_free) begin
							emit  = 1'b1;
							rsp_d = make_rsp(wbc_pkg::KIND_DONE, '0, '0,
								is_wr ? 32'd0 : wbc_pkg::size_mask(hit0 ? data_rdata0 : data_rdata1,
									item_q.access_size),
								1'b1, '0, hits_q + 32'd1, misses_q, 1'b1);
							if (is_wr) begin
								data_we    = 1'b1;
								data_waddr = daddr(hit0 ? line0 : line1, word32);
								data_wdata = wbc_pkg::merge_word(hit0 ? data_rdata0 : data_rdata1,
									item_q.write_data, item_q.access_size);
								meta_we    = 1'b1;
								meta_waddr = hit0 ? line0 : line1;
								meta_wdata = {1'b1, 1'b1, hit0 ? t0 : t1};
							end
							lru_we    = two_way_q;
							lru_wdata = !hit0;
						end
					end else begin
						lru_we    = two_way_q;
						lru_wdata = !lru_rdata;
					end
				end else if (!wb0 && !wb1 && out_free) begin
					emit  = 1'b1;
					rsp_d = make_rsp(wbc_pkg::KIND_STATUS, '0, '0, '0, 1'b0, stall_q,
						hits_q, misses_q, 1'b1);
				end
			end
			S_WB_RD, S_WB_OUT: begin
				data_raddr0 = daddr(wb_line_q, 32'(wb_word_q));
				if (state_q == S_WB_OUT && out_free) begin
					emit  = 1'b1;
					rsp_d = make_rsp(wbc_pkg::KIND_WB,
						base_of(32'(wb_tag_q), set32, two_way_q) + (32'(wb_word_q) << 2),
						data_rdata0, '0, 1'b0, '0, hits_q, misses_q,
						is_flush && wb_last_word && !wb_second_q);
					if (wb_last_word) begin
						meta_we    = 1'b1;
						meta_waddr = wb_line_q;
						meta_wdata = {1'b1, 1'b0, wb_tag_q};
					end
				end
			end
			S_REQ: begin
				if (out_free) begin
					emit       = 1'b1;
					rsp_d      = make_rsp(wbc_pkg::KIND_FILL_REQ, base_of(tag32, set32, two_way_q),
						'0, '0, 1'b0, miss_latency_q, hits_q, misses_q, 1'b1);
					meta_we    = 1'b1;
					meta_waddr = vic_line_q;
				end
			end
			S_FILL_WR: begin
				data_we    = 1'b1;
				data_waddr = daddr(pend_line_q, 32'(fill_cnt_q));
			end
			S_FILL_RD, S_FILL_DONE: begin
				data_raddr0 = daddr(pend_line_q, pword32);
				if (state_q == S_FILL_DONE && out_free) begin
					emit       = 1'b1;
					rsp_d      = make_rsp(wbc_pkg::KIND_DONE, '0, '0,
						pend_write_q ? 32'd0 : wbc_pkg::size_mask(data_rdata0, pend_size_q),
						1'b0, miss_latency_q, hits_q, misses_q, 1'b1);
					meta_we    = 1'b1;
					meta_waddr = pend_line_q;
					meta_wdata = {1'b1, pend_write_q, ptag32[TAGW-1:0]};
					data_we    = pend_write_q;
					data_waddr = daddr(pend_line_q, pword32);
					data_wdata = wbc_pkg::merge_word(data_rdata0, pend_data_q, pend_size_q);
				end
			end
			S_TICK: begin
				if (out_free) begin
					emit  = 1'b1;
					rsp_d = make_rsp(wbc_pkg::KIND_STATUS, '0, '0, '0, 1'b0, tick_new,
						hits_q, misses_q, 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			two_way_q      <= 1'b0;
			miss_latency_q <= '0;
			pend_valid_q   <= 1'b0;
			fill_cnt_q     <= '0;
			stall_q        <= '0;
			hits_q         <= '0;
			misses_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					wbc_pkg::REG_TWO_WAY:      two_way_q      <= cfg_data[0];
					wbc_pkg::REG_MISS_LATENCY: miss_latency_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MAW'(1);
					if (clr_q == MAW'(NUM_LINES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						case (req.command) inside
							wbc_pkg::CMD_READ, wbc_pkg::CMD_WRITE, wbc_pkg::CMD_FLUSH:
								state_q <= pend_valid_q ? S_IDLE : S_LOOK;
							wbc_pkg::CMD_FILL:
								state_q <= pend_valid_q ? S_FILL_WR : S_IDLE;
							wbc_pkg::CMD_TICK:
								state_q <= S_TICK;
							default:
								state_q <= S_IDLE;
						endcase
					end
				end
				S_LOOK: state_q <= S_CHECK;
				S_CHECK: begin
					if (!is_flush) begin
						if (hit_any) begin
							if (out_free) begin
								hits_q  <= hits_q + 32'd1;
								state_q <= S_IDLE;
							end
						end else begin
							misses_q <= misses_q + 32'd1;
							state_q  <= (vic_way1 ? (v1 && d1) : (v0 && d0)) ? S_WB_RD : S_REQ;
						end
					end else if (wb0 || wb1) begin
						state_q <= S_WB_RD;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_WB_RD: state_q <= S_WB_OUT;
				S_WB_OUT: begin
					if (out_free) begin
						if (wb_last_word && !wb_second_q) begin
							state_q <= is_flush ? S_IDLE : S_REQ;
						end else begin
							state_q <= S_WB_RD;
						end
					end
				end
				S_REQ: begin
					if (out_free) begin
						pend_valid_q <= 1'b1;
						fill_cnt_q   <= '0;
						stall_q      <= miss_latency_q;
						state_q      <= S_IDLE;
					end
				end
				S_FILL_WR: begin
					if (fill_next == CW'(WORDS_PER_LINE)) begin
						fill_cnt_q <= '0;
						state_q    <= S_FILL_RD;
					end else begin
						fill_cnt_q <= fill_next;
						state_q    <= S_IDLE;
					end
				end
				S_FILL_RD: state_q <= S_FILL_DONE;
				S_FILL_DONE: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				S_TICK: begin
					if (out_free) begin
						stall_q <= tick_new;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			item_q <= req;
		end
		if (emit) begin
			out_q <= rsp_d;
		end
		if (state_q == S_REQ) begin
			pend_addr_q  <= item_q.address;
			pend_data_q  <= item_q.write_data;
			pend_size_q  <= item_q.access_size;
			pend_write_q <= is_wr;
			pend_line_q  <= vic_line_q;
		end
		if (state_q == S_CHECK) begin
			wb_word_q <= '0;
			if (!is_flush) begin
				vic_line_q  <= vic_line;
				wb_line_q   <= vic_line;
				wb_tag_q    <= vic_way1 ? t1 : t0;
				wb_second_q <= 1'b0;
			end else begin
				wb_line_q   <= wb0 ? line0 : line1;
				wb_tag_q    <= wb0 ? t0 : t1;
				wb_tag1_q   <= t1;
				wb_second_q <= wb0 && wb1;
			end
		end
		if (state_q == S_WB_OUT && out_free) begin
			if (wb_last_word) begin
				wb_word_q <= '0;
				if (wb_second_q) begin
					wb_line_q   <= line1;
					wb_tag_q    <= wb_tag1_q;
					wb_second_q <= 1'b0;
				end
			end else begin
				wb_word_q <= wb_word_q + WW'(1);
			end
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`WBC_ASSERT(a_no_lookup_while_pending, (state_q == S_LOOK) |-> !pend_valid_q, "lookup with miss pending")
	`WBC_ASSERT_ALWAYS(a_fill_count_bound, fill_cnt_q < CW'(WORDS_PER_LINE), "fill count overrun")
	`WBC_ASSERT(a_fill_done_pending, (state_q == S_FILL_DONE) |-> pend_valid_q, "fill done, no miss")
	`WBC_ASSERT(a_result_from_work, $rose(rsp_valid) |-> ($past(state_q) != S_IDLE), "result from idle")

endmodule

[src/wbc_tag_store.sv]
module wbc_tag_store #(
	parameter int LINES     = 64,
	parameter int MW        = 29,
	parameter int AW        = 6,
	parameter int LRU_DEPTH = 32,
	parameter int LAW       = 5
) (
	input  logic          clk,
	input  logic          meta_we,
	input  logic [AW-1:0] meta_waddr,
	input  logic [MW-1:0] meta_wdata,
	input  logic [AW-1:0] meta_raddr0,
	input  logic [AW-1:0] meta_raddr1,
	output logic [MW-1:0] meta_rdata0,
	output logic [MW-1:0] meta_rdata1,
	input  logic          lru_we,
	input  logic [LAW-1:0] lru_waddr,
	input  logic          lru_wdata,
	input  logic [LAW-1:0] lru_raddr,
	output logic          lru_rdata
);

	logic [MW-1:0] meta_mem [LINES];
	logic          lru_mem [LRU_DEPTH];

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		meta_rdata0 <= meta_mem[meta_raddr0];
		meta_rdata1 <= meta_mem[meta_raddr1];
	end

	always_ff @(posedge clk) begin
		if (lru_we) begin
			lru_mem[lru_waddr] <= lru_wdata;
		end
		lru_rdata <= lru_mem[lru_raddr];
	end

endmodule

[src/wbc_data_store.sv]
module wbc_data_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [31:0]   rdata0,
	output logic [31:0]   rdata1
);

	logic [31:0] data_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			data_mem[waddr] <= wdata;
		end
		rdata0 <= data_mem[raddr0];
		rdata1 <= data_mem[raddr1];
	end

endmodule

[tb/cache_scoreboard.sv]
`timescale 1ns / 1ps

module cache_scoreboard (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [0:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          req_valid,
	input  logic          req_stall,
	input  wbc_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  wbc_pkg::rsp_t rsp,
	output int            failures,
	output int            outstanding,
	output int            checked,
	output bit            miss_pending
);

	localparam int LINES    = 64;
	localparam int WPL      = 4;
	localparam int OFS_BITS = 4;

	logic [31:0] tag_mem [LINES];
	bit          valid_mem [LINES];
	bit          dirty_mem [LINES];
	logic [31:0] word_mem [LINES * WPL];
	bit          way1_victim [LINES / 2];
	logic        two_way_on;
	logic [15:0] miss_lat;
	logic [15:0] stall_left;
	logic [31:0] hits;
	logic [31:0] misses;
	logic [31:0] pend_addr;
	logic [31:0] pend_wdata;
	logic [1:0]  pend_size;
	bit          pend_wr;
	int          pend_ln;
	int          fill_cnt;
	wbc_pkg::rsp_t due_responses [$];
	wbc_pkg::rsp_t batch [$];

	function automatic int set_bits();
		return two_way_on ? 5 : 6;
	endfunction

	function automatic logic [31:0] size_masked(input logic [31:0] v, input logic [1:0] sz);
		if (sz == wbc_pkg::SIZE_BYTE) return v & 32'hFF;
		if (sz == wbc_pkg::SIZE_HALF) return v & 32'hFFFF;
		return v;
	endfunction

	function automatic logic [31:0] store_merge(input logic [31:0] cur, input logic [31:0] v,
			input logic [1:0] sz);
		if (sz == wbc_pkg::SIZE_BYTE) return {cur[31:8], v[7:0]};
		if (sz == wbc_pkg::SIZE_HALF) return {cur[31:16], v[15:0]};
		return v;
	endfunction

	task automatic emit(input logic [1:0] kind, input logic [31:0] maddr, input logic [31:0] mdata,
			input logic [31:0] rdata, input logic hit, input logic [15:0] lat);
		wbc_pkg::rsp_t e;
		e.kind = kind;
		e.mem_address = maddr;
		e.mem_data = mdata;
		e.read_data = rdata;
		e.hit = hit;
		e.latency = lat;
		e.hit_count = hits;
		e.miss_count = misses;
		e.last = 1'b0;
		batch.push_back(e);
	endtask

	task automatic evict(input int ln, input int set);
		logic [31:0] base;
		if (valid_mem[ln] && dirty_mem[ln]) begin
			base = (tag_mem[ln] << (OFS_BITS + set_bits())) | (32'(set) << OFS_BITS);
			for (int i = 0; i < WPL; i++)
				emit(wbc_pkg::KIND_WB, base + 32'(i * 4), word_mem[ln * WPL + i], '0, 1'b0, '0);
			dirty_mem[ln] = 0;
		end
	endtask

	task automatic serve_request(input wbc_pkg::req_t r);
		int          sets;
		int          set;
		int          w;
		int          ln;
		logic [31:0] tag;
		logic [31:0] rd;
		bit          done;
		sets = 1 << set_bits();
		set = int'((r.address >> OFS_BITS) & 32'(sets - 1));
		tag = r.address >> (OFS_BITS + set_bits());
		w = int'(r.address[3:2]);
		done = 0;
		batch.delete();
		case (r.command)
			wbc_pkg::CMD_READ, wbc_pkg::CMD_WRITE: begin
				if (!miss_pending) begin
					for (int i = 0; i < (two_way_on ? 2 : 1); i++) begin
						ln = i * sets + set;
						if (!done && valid_mem[ln] && tag_mem[ln] == tag) begin
							done = 1;
							hits++;
							rd = 0;
							if (r.command == wbc_pkg::CMD_WRITE) begin
								word_mem[ln * WPL + w] = store_merge(word_mem[ln * WPL + w],
									r.write_data, r.access_size);
								dirty_mem[ln] = 1;
							end else begin
								rd = size_masked(word_mem[ln * WPL + w], r.access_size);
							end
							if (two_way_on) way1_victim[set] = (i == 1);
							emit(wbc_pkg::KIND_DONE, '0, '0, rd, 1'b1, '0);
						end
					end
					if (!done) begin
						misses++;
						if (!two_way_on) begin
							ln = set;
						end else if (way1_victim[set]) begin
							ln = set;
							way1_victim[set] = 0;
						end else begin
							ln = sets + set;
							way1_victim[set] = 1;
						end
						evict(ln, set);
						valid_mem[ln] = 0;
						dirty_mem[ln] = 0;
						emit(wbc_pkg::KIND_FILL_REQ, (tag << (OFS_BITS + set_bits())) |
							(32'(set) << OFS_BITS), '0, '0, 1'b0, miss_lat);
						miss_pending = 1;
						pend_addr = r.address;
						pend_wdata = r.write_data;
						pend_size = r.access_size;
						pend_wr = (r.command == wbc_pkg::CMD_WRITE);
						pend_ln = ln;
						fill_cnt = 0;
						stall_left = miss_lat;
					end
				end
			end
			wbc_pkg::CMD_FILL: begin
				if (miss_pending) begin
					word_mem[pend_ln * WPL + fill_cnt] = r.write_data;
					fill_cnt++;
					if (fill_cnt == WPL) begin
						fill_cnt = 0;
						miss_pending = 0;
						valid_mem[pend_ln] = 1;
						dirty_mem[pend_ln] = 0;
						tag_mem[pend_ln] = pend_addr >> (OFS_BITS + set_bits());
						w = pend_ln * WPL + int'(pend_addr[3:2]);
						rd = 0;
						if (pend_wr) begin
							word_mem[w] = store_merge(word_mem[w], pend_wdata, pend_size);
							dirty_mem[pend_ln] = 1;
						end else begin
							rd = size_masked(word_mem[w], pend_size);
						end
						emit(wbc_pkg::KIND_DONE, '0, '0, rd, 1'b0, miss_lat);
					end
				end
			end
			wbc_pkg::CMD_TICK: begin
				stall_left = (r.cycles > stall_left) ? 16'd0 : stall_left - r.cycles;
				emit(wbc_pkg::KIND_STATUS, '0, '0, '0, 1'b0, stall_left);
			end
			wbc_pkg::CMD_FLUSH: begin
				if (!miss_pending) begin
					evict(set, set);
					if (two_way_on) evict(sets + set, set);
					if (batch.size() == 0) emit(wbc_pkg::KIND_STATUS, '0, '0, '0, 1'b0, stall_left);
				end
			end
			default: ;
		endcase
		if (batch.size() > 0) begin
			batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) due_responses.push_back(batch[i]);
		end
	endtask

	task automatic compare_response(input wbc_pkg::rsp_t got);
		wbc_pkg::rsp_t exp;
		if (due_responses.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected response kind=%0d addr=%h data=%h", got.kind,
					got.mem_address, got.mem_data);
			return;
		end
		exp = due_responses.pop_front();
		checked++;
		if (got.kind !== exp.kind || got.mem_address !== exp.mem_address ||
				got.mem_data !== exp.mem_data || got.read_data !== exp.read_data ||
				got.hit !== exp.hit || got.latency !== exp.latency ||
				got.hit_count !== exp.hit_count || got.miss_count !== exp.miss_count ||
				got.last !== exp.last) begin
			failures++;
			if (failures <= 10) begin
				$display("mismatch at %0t", $realtime);
				$display("  exp kind=%0d maddr=%h mdata=%h rdata=%h hit=%0d lat=%0d hc=%0d mc=%0d last=%0d",
					exp.kind, exp.mem_address, exp.mem_data, exp.read_data, exp.hit,
					exp.latency, exp.hit_count, exp.miss_count, exp.last);
				$display("  got kind=%0d maddr=%h mdata=%h rdata=%h hit=%0d lat=%0d hc=%0d mc=%0d last=%0d",
					got.kind, got.mem_address, got.mem_data, got.read_data, got.hit,
					got.latency, got.hit_count, got.miss_count, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				tag_mem[i] = 0;
				valid_mem[i] = 0;
				dirty_mem[i] = 0;
			end
			for (int i = 0; i < LINES * WPL; i++) word_mem[i] = 0;
			for (int i = 0; i < LINES / 2; i++) way1_victim[i] = 1;
			two_way_on = 0;
			miss_lat = 0;
			stall_left = 0;
			hits = 0;
			misses = 0;
			miss_pending = 0;
			pend_addr = 0;
			pend_wdata = 0;
			pend_size = 0;
			pend_wr = 0;
			pend_ln = 0;
			fill_cnt = 0;
			failures = 0;
			checked = 0;
			due_responses.delete();
		end else begin
			if (cfg_write) begin
				if (cfg_index == wbc_pkg::REG_TWO_WAY) two_way_on = cfg_data[0];
				else miss_lat = cfg_data;
			end
			if (rsp_valid && !rsp_stall) compare_response(rsp);
			if (req_valid && !req_stall) serve_request(req);
		end
		outstanding = due_responses.size();
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	logic          clk;
	logic          arst_n;
	logic          cfg_write;
	logic [0:0]    cfg_index;
	logic [15:0]   cfg_data;
	logic          req_valid;
	logic          req_stall;
	wbc_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	wbc_pkg::rsp_t rsp;
	int            failures;
	int            outstanding;
	int            checked;
	bit            miss_pending;
	int            send_idle_pct;
	int            rsp_stall_pct;
	bit            hold_rsp;
	int            sent;
	int            phase_start;
	bit            mid_drained;
	logic [31:0]   addr_pool [4];

	writeback_cache_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	cache_scoreboard scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.failures(failures), .outstanding(outstanding), .checked(checked),
		.miss_pending(miss_pending)
	);

	initial clk = 0;
	always #1 clk = ~clk;

	initial begin
		#3000000;
		$display("testbench NOT OK");
		$finish;
	end

	always @(negedge clk) begin
		rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
	end

	task automatic send(input logic [2:0] cmd, input logic [31:0] addr, input logic [31:0] wdata,
			input logic [1:0] sz, input logic [15:0] cyc);
		wbc_pkg::req_t r;
		r.command = cmd;
		r.address = addr;
		r.write_data = wdata;
		r.access_size = sz;
		r.cycles = cyc;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic fill_line(input int words);
		for (int i = 0; i < words; i++)
			send(wbc_pkg::CMD_FILL, $urandom, $urandom, 2'($urandom_range(3)), 16'($urandom));
	endtask

	task automatic access(input logic [2:0] cmd, input logic [31:0] addr, input logic [1:0] sz);
		send(cmd, addr, $urandom, sz, 16'($urandom));
		if (miss_pending) fill_line(4);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_write <= 1'b1;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		if ($urandom_range(19) == 0) return $urandom;
		a = addr_pool[$urandom_range(3)] & 32'hFFFF_FF80;
		return a | ($urandom_range(7) << 4) | $urandom_range(15);
	endfunction

	task automatic random_request();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 60) begin
			access($urandom_range(1) ? wbc_pkg::CMD_WRITE : wbc_pkg::CMD_READ, pick_addr(),
				2'($urandom_range(3)));
		end else if (pick < 72) begin
			send(wbc_pkg::CMD_TICK, $urandom, $urandom, 2'($urandom_range(3)),
				$urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(40)));
		end else if (pick < 82) begin
			send(wbc_pkg::CMD_FLUSH, pick_addr(), $urandom, 2'($urandom_range(3)), 16'($urandom));
		end else if (pick < 90) begin
			send(3'($urandom_range(7)), $urandom, $urandom, 2'($urandom_range(3)), 16'($urandom));
		end else begin
			send($urandom_range(1) ? wbc_pkg::CMD_WRITE : wbc_pkg::CMD_READ, pick_addr(), $urandom,
				2'($urandom_range(3)), 16'($urandom));
			if (miss_pending) begin
				n = $urandom_range(1, 3);
				fill_line(n);
				send($urandom_range(1) ? wbc_pkg::CMD_FLUSH : wbc_pkg::CMD_READ, pick_addr(),
					$urandom, 2'd0, 16'($urandom));
				fill_line(4 - n);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_write = 0;
		cfg_index = wbc_pkg::REG_TWO_WAY;
		cfg_data = 0;
		req_valid = 0;
		req = '0;
		rsp_stall = 0;
		hold_rsp = 0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		sent = 0;
		phase_start = 0;
		mid_drained = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, every command, corner cases
		write_reg(wbc_pkg::REG_MISS_LATENCY, 16'hFFFF);
		access(wbc_pkg::CMD_READ, 32'h0000_0000, 2'd2);
		access(wbc_pkg::CMD_WRITE, 32'hFFFF_FFFF, 2'd0);
		access(wbc_pkg::CMD_WRITE, 32'hFFFF_FFFE, 2'd1);
		access(wbc_pkg::CMD_WRITE, 32'hFFFF_FFF4, 2'd3);
		access(wbc_pkg::CMD_READ, 32'hFFFF_FFFF, 2'd2);
		send(wbc_pkg::CMD_TICK, 32'd0, 32'd0, 2'd0, 16'd0);
		send(wbc_pkg::CMD_TICK, 32'd0, 32'd0, 2'd0, 16'd5);
		send(wbc_pkg::CMD_TICK, 32'd0, 32'd0, 2'd0, 16'hFFFF);
		send(wbc_pkg::CMD_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 16'hFFFF);
		send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 16'hFFFF);
		send(3'd5, 32'd0, 32'd0, 2'd0, 16'd0);
		send(wbc_pkg::CMD_READ, 32'h0000_03F0, 32'd0, 2'd2, 16'd0);
		send(wbc_pkg::CMD_WRITE, 32'h0000_03F0, 32'd0, 2'd2, 16'd0);
		send(wbc_pkg::CMD_FLUSH, 32'h0000_03F0, 32'd0, 2'd0, 16'd0);
		send(wbc_pkg::CMD_TICK, 32'd0, 32'd0, 2'd0, 16'd1);
		fill_line(4);
		send(wbc_pkg::CMD_FLUSH, 32'hFFFF_FFF0, 32'd0, 2'd0, 16'd0);
		send(wbc_pkg::CMD_FLUSH, 32'hFFFF_FFF0, 32'd0, 2'd0, 16'd0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 46 : 0;
			rsp_stall_pct = (ph == 2 || ph == 3) ? 46 : 0;
			if (ph == 3) begin
				send_idle_pct = 12;
				rsp_stall_pct = 12;
			end
			write_reg(wbc_pkg::REG_TWO_WAY, {15'd0, ph[0]});
			write_reg(wbc_pkg::REG_MISS_LATENCY,
				ph == 0 ? 16'd0 : ph == 1 ? 16'hFFFF : 16'($urandom));
			foreach (addr_pool[i]) addr_pool[i] = $urandom;
			if (ph == 0)
				fork
					begin
						hold_rsp = 1;
						repeat (300) @(negedge clk);
						hold_rsp = 0;
					end
				join_none
			phase_start = sent;
			mid_drained = 0;
			while (sent - phase_start < 115) begin
				random_request();
				if (!mid_drained && sent - phase_start >= 55) begin
					drain();
					mid_drained = 1;
				end
			end
			drain();
		end

		$display("sent %0d requests over four idling phases, direct-mapped and two-way,",
			sent);
		$display("miss latency 0 to 65535; %0d responses checked", checked);
		if (failures == 0 && outstanding == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/wbc_pkg.sv
src/wbc_tag_store.sv
src/wbc_data_store.sv
src/writeback_cache_controller.sv
tb/cache_scoreboard.sv
tb/testbench.sv
